[design/gdfw_pkg.sv]
package gdfw_pkg;

    localparam int NODES       = 16;
    localparam int MAX_DEGREE  = 8;
    localparam int STACK_DEPTH = 32;
    localparam int RESULT_CAP  = 16;

    // Field widths are fixed by the item format
    localparam int NODE_W = 4;

    localparam int NIDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int NT_DEPTH = NODES * MAX_DEGREE;
    localparam int NT_AW  = (NT_DEPTH > 1) ? $clog2(NT_DEPTH) : 1;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RESULT_CAP + 1);
    localparam int CMP_W  = 8;

    typedef struct packed {
        logic load;
        logic edge_add;
        logic init;
        logic pop;
        logic visit;
        logic nb_rd;
        logic nb_push;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic src_ok;
        logic stack_empty;
        logic count_full;
        logic node_ok;
        logic deg_more;
    } t_status;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    function automatic logic [NT_AW-1:0] nt_addr(input logic [NODE_W-1:0] node,
                                                 input logic [DEG_W-1:0] slot);
        nt_addr = NT_AW'(node) * NT_AW'(MAX_DEGREE) + NT_AW'(slot);
    endfunction

    function automatic logic node_in_range(input logic [NODE_W-1:0] node);
        node_in_range = (CMP_W'(node) < CMP_W'(NODES));
    endfunction

endpackage

[design/gdfw_ram.sv]
module gdfw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/gdfw_ctrl.sv]
module gdfw_ctrl
    import gdfw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_CHECK,
        S_NB_RD,
        S_NB_PUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.kind == KIND_EDGE) begin
                    o_cmd.edge_add = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_status.src_ok) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_POP;
                end else begin
                    // start node out of range: no word at all
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (i_status.stack_empty || i_status.count_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.node_ok) begin
                    o_cmd.visit = 1'b1;
                    n_state     = S_NB_RD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_NB_RD: begin
                if (i_status.deg_more) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state     = S_NB_PUSH;
                end else begin
                    n_state = S_POP;
                end
            end
            S_NB_PUSH: begin
                o_cmd.nb_push = 1'b1;
                n_state       = S_NB_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

`ifndef SYNTH
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(o_cmd.edge_add || o_cmd.init || o_cmd.pop ||
                                   o_cmd.visit || o_cmd.nb_rd || o_cmd.nb_push ||
                                   o_cmd.finish))
        else $error("command issued while idle");
    a_finish_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_busy)
        else $error("still busy after walk end");
    a_visit_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.visit |=> (r_state == S_NB_RD))
        else $error("visit not followed by neighbour scan");
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy == (r_state != S_IDLE))
        else $error("busy out of step with state");
`endif

endmodule

[design/gdfw_dpath.sv]
module gdfw_dpath
    import gdfw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_kind,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    output t_status           o_status,
    output logic              o_valid,
    output logic [NODE_W-1:0] o_visited_node,
    output logic              o_last,
    output logic              o_accepted
);

    // latched item
    logic              r_kind;
    logic [NODE_W-1:0] r_src;
    logic [NODE_W-1:0] r_dst;

    logic [DEG_W-1:0]  r_degree [NODES];
    logic [NODES-1:0]  r_visited;
    logic [SP_W-1:0]   r_fill;
    logic [CNT_W-1:0]  r_count;
    logic [NODE_W-1:0] r_node;
    logic [DEG_W-1:0]  r_slot;
    logic              r_pend_valid;
    logic [NODE_W-1:0] r_pend_node;

    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    logic              r_out_last;
    logic              r_out_acc;

    logic [NODE_W-1:0] deg_node;
    logic [DEG_W-1:0]  deg_sel;
    logic              edge_ok;
    logic              stack_full;
    logic              st_we;
    logic [SA_W-1:0]   st_waddr;
    logic [NODE_W-1:0] st_wdata;
    logic [SA_W-1:0]   st_raddr;
    logic [NODE_W-1:0] st_rdata;
    logic              nt_we;
    logic [NT_AW-1:0]  nt_waddr;
    logic [NT_AW-1:0]  nt_raddr;
    logic [NODE_W-1:0] nt_rdata;

    always_comb begin
        // edges look at the source node, walks at the node being expanded
        deg_node   = (r_kind == KIND_SEARCH) ? r_node : r_src;
        deg_sel    = r_degree[NIDX_W'(deg_node)];
        edge_ok    = node_in_range(r_src) && node_in_range(r_dst) &&
                     (deg_sel < DEG_W'(MAX_DEGREE));
        stack_full = (r_fill == SP_W'(STACK_DEPTH));

        st_we    = i_cmd.init || (i_cmd.nb_push && !stack_full);
        st_waddr = i_cmd.init ? '0 : r_fill[SA_W-1:0];
        st_wdata = i_cmd.init ? r_src : nt_rdata;
        st_raddr = SA_W'(r_fill - SP_W'(1));

        nt_we    = i_cmd.edge_add && edge_ok;
        nt_waddr = nt_addr(r_src, deg_sel);
        nt_raddr = nt_addr(r_node, r_slot);

        o_status.kind        = r_kind;
        o_status.src_ok      = node_in_range(r_src);
        o_status.stack_empty = (r_fill == '0);
        o_status.count_full  = (r_count >= CNT_W'(RESULT_CAP));
        o_status.node_ok     = node_in_range(st_rdata) && !r_visited[NIDX_W'(st_rdata)];
        o_status.deg_more    = (r_slot < deg_sel);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_src  <= i_from_node;
            r_dst  <= i_to_node;
        end
        if (i_cmd.visit) begin
            r_node      <= st_rdata;
            r_pend_node <= st_rdata;
        end
        if (i_cmd.visit) begin
            r_slot <= '0;
        end else if (i_cmd.nb_push) begin
            r_slot <= r_slot + DEG_W'(1);
        end
        r_out_node <= '0;
        r_out_last <= 1'b1;
        r_out_acc  <= 1'b1;
        if (i_cmd.edge_add) begin
            r_out_acc <= edge_ok;
        end else if (i_cmd.visit || i_cmd.finish) begin
            // hold one node back so the final one can carry the last mark
            r_out_node <= r_pend_node;
            r_out_last <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_degree[i] <= '0;
            end
            r_visited    <= '0;
            r_fill       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.edge_add ||
                           ((i_cmd.visit || i_cmd.finish) && r_pend_valid);
            if (nt_we) begin
                r_degree[NIDX_W'(r_src)] <= deg_sel + DEG_W'(1);
            end
            if (i_cmd.init) begin
                r_visited    <= '0;
                r_fill       <= SP_W'(1);
                r_count      <= '0;
                r_pend_valid <= 1'b0;
            end else begin
                if (i_cmd.pop) begin
                    r_fill <= r_fill - SP_W'(1);
                end else if (i_cmd.nb_push && !stack_full) begin
                    r_fill <= r_fill + SP_W'(1);
                end
                if (i_cmd.visit) begin
                    r_visited[NIDX_W'(st_rdata)] <= 1'b1;
                    r_count      <= r_count + CNT_W'(1);
                    r_pend_valid <= 1'b1;
                end else if (i_cmd.finish) begin
                    r_pend_valid <= 1'b0;
                end
            end
        end
    end

    gdfw_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NT_DEPTH)
    ) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_waddr (nt_waddr),
        .i_wdata (r_dst),
        .i_raddr (nt_raddr),
        .o_rdata (nt_rdata)
    );

    gdfw_ram #(
        .WIDTH (NODE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_valid        = r_out_valid;
    assign o_visited_node = r_out_node;
    assign o_last         = r_out_last;
    assign o_accepted     = r_out_acc;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SP_W'(STACK_DEPTH))
        else $error("stack fill beyond depth");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RESULT_CAP))
        else $error("visit count beyond cap");
    a_pend_after_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_pend_valid)
        else $error("mid-walk word sent with no node held back");
`endif

endmodule

[design/graph_depth_first_walk.sv]
// Depth-first walk over a directed graph of NODES nodes with up to MAX_DEGREE
// neighbours each. Raise start with i_kind, i_from_node and i_to_node while
// busy is low. An add-edge item gives one word once dispatched (o_last = 1,
// o_accepted = 0 if the list was full or a node out of range). A search gives
// one word per newly visited node in walk order, o_last on the final one; a
// start node out of range gives no word. Words appear on o_valid for a single
// cycle and must be taken then. A search keeps busy high until the walk ends:
// the neighbour table and the stack each sit in a RAM with registered read,
// one entry read per access, so every stack pop and every neighbour push
// passes through a read state and then a use state. An add-edge item keeps
// busy high for one cycle after acceptance.
module graph_depth_first_walk
    import gdfw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_kind,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    output logic              busy,
    output logic              o_valid,
    output logic [NODE_W-1:0] o_visited_node,
    output logic              o_last,
    output logic              o_accepted
);

    t_cmd    cmd;
    t_status status;

    gdfw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    gdfw_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_visited_node (o_visited_node),
        .o_last         (o_last),
        .o_accepted     (o_accepted)
    );

endmodule

[bench/dfs_walk_monitor.sv]
`default_nettype none

module dfs_walk_monitor
    import gdfw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              i_kind,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    input  logic              o_valid,
    input  logic [NODE_W-1:0] o_visited_node,
    input  logic              o_last,
    input  logic              o_accepted,
    output int                fail_count,
    output int                words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
        logic              acc;
    } t_walk_word;

    logic [NODE_W-1:0] adj_list [NODES][MAX_DEGREE];
    int                out_degree [NODES];
    t_walk_word        due_q [$];
    t_walk_word        head;
    int                fails = 0;
    int                shown = 0;
    int                n;

    task automatic edge_ack_word(input logic [NODE_W-1:0] src,
                                 input logic [NODE_W-1:0] dst);
        t_walk_word w;
        logic       stored;
        stored = (int'(src) < NODES) && (int'(dst) < NODES) &&
                 (out_degree[src] < MAX_DEGREE);
        if (stored) begin
            adj_list[src][out_degree[src]] = dst;
            out_degree[src]++;
        end
        w.node = '0;
        w.last = 1'b1;
        w.acc  = stored;
        due_q.push_back(w);
    endtask

    task automatic walk_order_words(input logic [NODE_W-1:0] root);
        logic [NODES-1:0]  seen;
        logic [NODE_W-1:0] lifo [STACK_DEPTH];
        logic [NODE_W-1:0] order [RESULT_CAP];
        logic [NODE_W-1:0] nd;
        int                fill;
        int                count;
        int                d;
        int                i;
        t_walk_word        w;
        // a start node out of range gives no word at all
        if (int'(root) < NODES) begin
            seen    = '0;
            lifo[0] = root;
            fill    = 1;
            count   = 0;
            while (fill > 0 && count < RESULT_CAP) begin
                fill--;
                nd = lifo[fill];
                if (int'(nd) < NODES && !seen[nd]) begin
                    seen[nd]     = 1'b1;
                    order[count] = nd;
                    count++;
                    // drop pushes once the stack is full
                    for (d = 0; d < out_degree[nd]; d++) begin
                        if (fill < STACK_DEPTH) begin
                            lifo[fill] = adj_list[nd][d];
                            fill++;
                        end
                    end
                end
            end
            for (i = 0; i < count; i++) begin
                w.node = order[i];
                w.last = (i == count - 1);
                w.acc  = 1'b1;
                due_q.push_back(w);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (n = 0; n < NODES; n++) begin
                out_degree[n] = 0;
            end
            due_q.delete();
        end else begin
            if (o_valid) begin
                if (due_q.size() == 0) begin
                    fails++;
                    if (shown < 10) begin
                        shown++;
                        $display("mismatch at %0t: unexpected word node %0d last %0b acc %0b",
                                 $realtime, o_visited_node, o_last, o_accepted);
                    end
                end else begin
                    head = due_q.pop_front();
                    if (o_visited_node !== head.node || o_last !== head.last
                        || o_accepted !== head.acc) begin
                        fails++;
                        if (shown < 10) begin
                            shown++;
                            $display("mismatch at %0t: want %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, head.node, head.last, head.acc,
                                     o_visited_node, o_last, o_accepted);
                        end
                    end
                end
            end
            if (start && !busy) begin
                if (i_kind == KIND_EDGE) begin
                    edge_ack_word(i_from_node, i_to_node);
                end else begin
                    walk_order_words(i_from_node);
                end
            end
        end
        words_due  <= due_q.size();
        fail_count <= fails;
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

module testbench
    import gdfw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_ITEMS = 280;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              i_kind;
    logic [NODE_W-1:0] i_from_node;
    logic [NODE_W-1:0] i_to_node;
    logic              busy;
    logic              o_valid;
    logic [NODE_W-1:0] o_visited_node;
    logic              o_last;
    logic              o_accepted;
    int                fail_count;
    int                words_due;
    int                idle_cycles = 0;
    int                burst_left = 0;
    logic              no_idle = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    graph_depth_first_walk uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_kind         (i_kind),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_visited_node (o_visited_node),
        .o_last         (o_last),
        .o_accepted     (o_accepted)
    );

    dfs_walk_monitor watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .o_valid        (o_valid),
        .o_visited_node (o_visited_node),
        .o_last         (o_last),
        .o_accepted     (o_accepted),
        .fail_count     (fail_count),
        .words_due      (words_due)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL graph_depth_first_walk");
            $finish;
        end
    end

    // alternate stretches of back-to-back words with stretches of random gaps
    function automatic int next_gap();
        if (burst_left == 0) begin
            burst_left = $urandom_range(8, 30);
            no_idle    = ($urandom_range(0, 2) == 0);
        end
        burst_left--;
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    // returns at the edge that takes the word; start stays high if the next has no gap
    task automatic send_word(input int gap, input logic kd,
                             input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_kind      <= kd;
        i_from_node <= src;
        i_to_node   <= dst;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        int                k;
        logic              kd;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;

        start       <= 1'b0;
        i_kind      <= KIND_EDGE;
        i_from_node <= '0;
        i_to_node   <= '0;
        i_rst_n     <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill node 0 to capacity, then overflow it
        send_word(next_gap(), KIND_EDGE, 4'd0, 4'd15);
        for (k = 1; k < MAX_DEGREE; k++) begin
            send_word(next_gap(), KIND_EDGE, 4'd0, NODE_W'(k));
        end
        send_word(next_gap(), KIND_EDGE, 4'd0, 4'd3);
        send_word(next_gap(), KIND_EDGE, 4'd15, 4'd0);
        send_word(next_gap(), KIND_EDGE, 4'd15, 4'd15);
        send_word(next_gap(), KIND_EDGE, 4'd1, 4'd1);
        send_word(next_gap(), KIND_EDGE, 4'd1, 4'd2);
        send_word(next_gap(), KIND_EDGE, 4'd1, 4'd2);
        send_word(next_gap(), KIND_SEARCH, 4'd0, 4'd15);
        send_word(next_gap(), KIND_SEARCH, 4'd15, 4'd0);
        send_word(next_gap(), KIND_SEARCH, 4'd9, 4'd9);
        send_word(next_gap(), KIND_SEARCH, 4'd1, 4'd0);

        // edge-heavy first half builds a dense graph, later searches overflow the stack
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            kd  = ($urandom_range(0, 99) < ((k < RANDOM_ITEMS / 2) ? 70 : 45))
                  ? KIND_EDGE : KIND_SEARCH;
            src = NODE_W'($urandom_range(0, NODES - 1));
            dst = NODE_W'($urandom_range(0, 15));
            send_word(next_gap(), kd, src, dst);
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && words_due == 0) begin
            $display("PASS graph_depth_first_walk");
        end else begin
            $display("FAIL graph_depth_first_walk");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/gdfw_pkg.sv
design/gdfw_ram.sv
design/gdfw_ctrl.sv
design/gdfw_dpath.sv
design/graph_depth_first_walk.sv
bench/dfs_walk_monitor.sv
bench/testbench.sv
